// ===== rtl/core/tcw_pkg.sv =====
`timescale 1ns / 1ps
// tcw_pkg: shared geometry constants, request/response/command types and codes
// for the text console writer. No dependencies.
package tcw_pkg;

   // Screen geometry
   localparam int COLUMNS    = 80;
   localparam int ROWS       = 25;
   localparam int TAB_WIDTH  = 8;
   localparam int CELL_COUNT = ROWS * COLUMNS;

   // Field widths fixed by the interface
   localparam int FUNC_W = 2;
   localparam int CHAR_W = 8;
   localparam int ATTR_W = 8;
   localparam int IDX_W  = 11;
   localparam int POS_W  = 11;
   localparam int CELL_W = 16;

   // Derived internal widths
   localparam int COL_W    = $clog2(COLUMNS);
   localparam int ROW_W    = $clog2(ROWS);
   localparam int ADDR_W   = $clog2(CELL_COUNT);
   localparam int PHASE_W  = $clog2(TAB_WIDTH);
   localparam int TABSUM_W = $clog2(COLUMNS + TAB_WIDTH);

   // index / COLUMNS as (index * RECIP_MUL) >> RECIP_SHIFT; exact for any
   // index below 2**IDX_W while COLUMNS stays at or below 512
   localparam int RECIP_SHIFT = IDX_W + 9;
   localparam int RECIP_MUL   = (2 ** RECIP_SHIFT + COLUMNS - 1) / COLUMNS;

   // Command queue depth
   localparam int QDEPTH = 2;
   localparam int QPTR_W = $clog2(QDEPTH);
   localparam int QCNT_W = $clog2(QDEPTH + 1);

   // Request function codes
   localparam logic [FUNC_W-1:0] FUNC_PUT   = 2'd0;
   localparam logic [FUNC_W-1:0] FUNC_CLEAR = 2'd1;
   localparam logic [FUNC_W-1:0] FUNC_READ  = 2'd2;

   // Character codes
   localparam logic [CHAR_W-1:0] CH_BS    = 8'h08;
   localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;
   localparam logic [CHAR_W-1:0] CH_LF    = 8'h0A;
   localparam logic [CHAR_W-1:0] CH_CR    = 8'h0D;
   localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;

   localparam logic [ATTR_W-1:0] ATTR_RESET = 8'h0F;

   // Decoded operation codes passed from front end to back end
   localparam int OP_W = 3;
   localparam logic [OP_W-1:0] OP_NOP   = 3'd0;
   localparam logic [OP_W-1:0] OP_PRINT = 3'd1;
   localparam logic [OP_W-1:0] OP_BS    = 3'd2;
   localparam logic [OP_W-1:0] OP_TAB   = 3'd3;
   localparam logic [OP_W-1:0] OP_CR    = 3'd4;
   localparam logic [OP_W-1:0] OP_LF    = 3'd5;
   localparam logic [OP_W-1:0] OP_CLEAR = 3'd6;
   localparam logic [OP_W-1:0] OP_READ  = 3'd7;

   typedef struct packed {
      logic [FUNC_W-1:0] func;
      logic [CHAR_W-1:0] char_code;
      logic [IDX_W-1:0]  cell_index;
   } req_type;

   typedef struct packed {
      logic [POS_W-1:0]  cursor_pos;
      logic [CELL_W-1:0] cell_value;
   } rsp_type;

   typedef struct packed {
      logic [OP_W-1:0]   op;
      logic [CHAR_W-1:0] char_code;
      logic [IDX_W-1:0]  cell_index;
   } cmd_type;

endpackage

// ===== rtl/core/text_console_writer.sv =====
`timescale 1ns / 1ps
// text_console_writer: top level of the 80x25 text console (front end,
// command queue, back end). Depends on tcw_pkg, tcw_front, tcw_queue, tcw_back.
//
//   channel   direction  handshake            payload
//   req_*     in         req_valid/req_stall  tcw_pkg::req_type (func, char, index)
//   rsp_*     out        rsp_valid/rsp_stall  tcw_pkg::rsp_type (cursor, cell)
//   csr_*     in         csr_valid/csr_ready  text attribute byte
//
// The back end runs one command at a time. A printable char whose row was
// blanked by a scroll or clear must first have that row painted; an in-range
// read divides by COLUMNS with a reciprocal, then takes the column, then
// reads the cell, which it skips when its row is still blank.
// Scroll and clear write no cells: they update a rotating row offset plus
// per-row valid bits and blank attributes, so reset needs no memory clearing pass.
// Synchronous active-high reset. A two-entry queue decouples req from the
// back end; the response register lets the back end finish while rsp stalls.
module text_console_writer (
   input  logic                       clock,
   input  logic                       reset,
   // request channel
   input  logic                       req_valid,
   output logic                       req_stall,
   input  tcw_pkg::req_type           req_data,
   // response channel
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output tcw_pkg::rsp_type           rsp_data,
   // attribute register write
   input  logic                       csr_valid,
   output logic                       csr_ready,
   input  logic [tcw_pkg::ATTR_W-1:0] csr_wdata
);

   // front end -> queue
   logic             q_push;
   logic             q_full;
   tcw_pkg::cmd_type q_push_cmd;
   // queue -> back end
   logic             q_pop;
   logic             q_valid;
   tcw_pkg::cmd_type q_pop_cmd;

   // decode: control codes, clear and read become back-end op codes
   tcw_front u_front (
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .q_full    (q_full),
      .q_push    (q_push),
      .q_cmd     (q_push_cmd)
   );

   tcw_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_cmd  (q_push_cmd),
      .full      (q_full),
      .pop       (q_pop),
      .pop_valid (q_valid),
      .pop_cmd   (q_pop_cmd)
   );

   // execution: cell memory, cursor, scroll offset, response register
   tcw_back u_back (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_wdata (csr_wdata),
      .q_valid   (q_valid),
      .q_cmd     (q_pop_cmd),
      .q_pop     (q_pop),
      .rsp_stall (rsp_stall),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

endmodule

// ===== rtl/core/tcw_front.sv =====
`timescale 1ns / 1ps
// tcw_front: accepts requests and decodes them into back-end commands.
// Depends on tcw_pkg.
module tcw_front (
   input  logic             req_valid,
   output logic             req_stall,
   input  tcw_pkg::req_type req_data,
   input  logic             q_full,
   output logic             q_push,
   output tcw_pkg::cmd_type q_cmd
);

   logic in_range;

   assign in_range  = 32'(req_data.cell_index) < tcw_pkg::CELL_COUNT;
   assign req_stall = q_full;
   assign q_push    = req_valid && !q_full;

   always_comb begin
      q_cmd.char_code  = req_data.char_code;
      q_cmd.cell_index = req_data.cell_index;
      q_cmd.op         = tcw_pkg::OP_NOP;
      unique case (req_data.func)
         tcw_pkg::FUNC_PUT: begin
            priority if (req_data.char_code == tcw_pkg::CH_BS)       q_cmd.op = tcw_pkg::OP_BS;
            else if (req_data.char_code == tcw_pkg::CH_TAB)          q_cmd.op = tcw_pkg::OP_TAB;
            else if (req_data.char_code == tcw_pkg::CH_CR)           q_cmd.op = tcw_pkg::OP_CR;
            else if (req_data.char_code == tcw_pkg::CH_LF)           q_cmd.op = tcw_pkg::OP_LF;
            else if (req_data.char_code >= tcw_pkg::CH_SPACE)        q_cmd.op = tcw_pkg::OP_PRINT;
            else                                                     q_cmd.op = tcw_pkg::OP_NOP;
         end
         tcw_pkg::FUNC_CLEAR: q_cmd.op = tcw_pkg::OP_CLEAR;
         // out-of-range reads just report the cursor with a zero value
         tcw_pkg::FUNC_READ:  q_cmd.op = in_range ? tcw_pkg::OP_READ : tcw_pkg::OP_NOP;
         default:             q_cmd.op = tcw_pkg::OP_NOP;
      endcase
   end

endmodule

// ===== rtl/core/tcw_queue.sv =====
`timescale 1ns / 1ps
// tcw_queue: short command FIFO between front end and back end.
// Depends on tcw_pkg.
module tcw_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  tcw_pkg::cmd_type push_cmd,
   output logic             full,
   input  logic             pop,
   output logic             pop_valid,
   output tcw_pkg::cmd_type pop_cmd
);

   localparam int QPTR_W = tcw_pkg::QPTR_W;
   localparam int QCNT_W = tcw_pkg::QCNT_W;

   tcw_pkg::cmd_type  slot_ff [tcw_pkg::QDEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0] count_ff, count_in;
   logic              do_push, do_pop;

   assign full      = count_ff == QCNT_W'(tcw_pkg::QDEPTH);
   assign pop_valid = count_ff != '0;
   assign pop_cmd   = slot_ff[rd_ptr_ff];
   assign do_push   = push && !full;
   assign do_pop    = pop && pop_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_W'(tcw_pkg::QDEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_W'(tcw_pkg::QDEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

// ===== rtl/core/tcw_back.sv =====
`timescale 1ns / 1ps
// tcw_back: executes decoded commands against the cell memory and cursor,
// holds the attribute register and the response register. Depends on tcw_pkg.
module tcw_back (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [tcw_pkg::ATTR_W-1:0]    csr_wdata,
   input  logic                          q_valid,
   input  tcw_pkg::cmd_type              q_cmd,
   output logic                          q_pop,
   input  logic                          rsp_stall,
   output logic                          rsp_valid,
   output tcw_pkg::rsp_type              rsp_data
);

   localparam int ROWS     = tcw_pkg::ROWS;
   localparam int COL_W    = tcw_pkg::COL_W;
   localparam int ROW_W    = tcw_pkg::ROW_W;
   localparam int ADDR_W   = tcw_pkg::ADDR_W;
   localparam int PHASE_W  = tcw_pkg::PHASE_W;
   localparam int TABSUM_W = tcw_pkg::TABSUM_W;
   localparam int IDX_W    = tcw_pkg::IDX_W;
   localparam int POS_W    = tcw_pkg::POS_W;
   localparam int CELL_W   = tcw_pkg::CELL_W;
   localparam int ATTR_W   = tcw_pkg::ATTR_W;
   localparam int SUM_W    = ROW_W + 1;
   localparam int PROD_W   = IDX_W + tcw_pkg::RECIP_SHIFT;

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_FILL  = 3'd1;
   localparam logic [2:0] ST_WRITE = 3'd2;
   localparam logic [2:0] ST_DIV   = 3'd3;
   localparam logic [2:0] ST_LOOK  = 3'd4;
   localparam logic [2:0] ST_RDATA = 3'd5;
   localparam logic [2:0] ST_DONE  = 3'd6;
   localparam logic [2:0] ST_REM   = 3'd7;

   // logical row -> physical row under the scroll offset
   function automatic logic [ROW_W-1:0] phys_row(input logic [ROW_W-1:0] r,
                                                 input logic [ROW_W-1:0] t);
      logic [SUM_W-1:0] s;
      s = {1'b0, r} + {1'b0, t};
      if (s >= SUM_W'(ROWS)) begin
         s = s - SUM_W'(ROWS);
      end
      return s[ROW_W-1:0];
   endfunction

   function automatic logic [ADDR_W-1:0] cell_addr(input logic [ROW_W-1:0] p,
                                                   input logic [COL_W-1:0] c);
      return ADDR_W'(p) * ADDR_W'(tcw_pkg::COLUMNS) + ADDR_W'(c);
   endfunction

   logic [2:0]             state_ff, state_in;
   logic [ATTR_W-1:0]      attr_ff, attr_in;
   logic [COL_W-1:0]       col_ff, col_in;
   logic [PHASE_W-1:0]     phase_ff, phase_in;
   logic [ROW_W-1:0]       row_ff, row_in;
   logic [ROW_W-1:0]       top_ff, top_in;
   logic [ROWS-1:0]        row_valid_ff, row_valid_in;
   logic [ATTR_W-1:0]      row_attr_ff [ROWS];
   logic [ATTR_W-1:0]      row_attr_in [ROWS];
   tcw_pkg::cmd_type       cmd_ff, cmd_in;
   logic [COL_W-1:0]       fill_ff, fill_in;
   logic [IDX_W-1:0]       rem_ff, rem_in;
   logic [ROW_W-1:0]       quo_ff, quo_in;
   logic [ROW_W-1:0]       prow_ff, prow_in;
   logic [CELL_W-1:0]      value_ff, value_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   tcw_pkg::rsp_type       rsp_data_ff, rsp_data_in;

   logic [CELL_W-1:0]      cells [tcw_pkg::CELL_COUNT];
   logic [CELL_W-1:0]      rd_data_ff;
   logic                   mem_we;
   logic [ADDR_W-1:0]      mem_waddr, mem_raddr;
   logic [CELL_W-1:0]      mem_wdata;

   logic [ROW_W-1:0]       cur_prow, look_prow;
   logic [TABSUM_W-1:0]    tab_col;
   logic [ADDR_W-1:0]      cur_lin;
   logic [PROD_W-1:0]      quo_prod;
   logic                   adv_row;

   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   assign cur_prow  = phys_row(row_ff, top_ff);
   assign look_prow = phys_row(quo_ff, top_ff);
   assign tab_col   = TABSUM_W'(col_ff) + TABSUM_W'(tcw_pkg::TAB_WIDTH) - TABSUM_W'(phase_ff);
   assign cur_lin   = ADDR_W'(row_ff) * ADDR_W'(tcw_pkg::COLUMNS) + ADDR_W'(col_ff);
   assign quo_prod  = PROD_W'(rem_ff) * PROD_W'(tcw_pkg::RECIP_MUL);

   always_comb begin
      state_in     = state_ff;
      attr_in      = attr_ff;
      col_in       = col_ff;
      phase_in     = phase_ff;
      row_in       = row_ff;
      top_in       = top_ff;
      row_valid_in = row_valid_ff;
      row_attr_in  = row_attr_ff;
      cmd_in       = cmd_ff;
      fill_in      = fill_ff;
      rem_in       = rem_ff;
      quo_in       = quo_ff;
      prow_in      = prow_ff;
      value_in     = value_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      q_pop        = 1'b0;
      mem_we       = 1'b0;
      mem_waddr    = cell_addr(cur_prow, col_ff);
      mem_wdata    = {attr_ff, cmd_ff.char_code};
      mem_raddr    = cell_addr(look_prow, rem_ff[COL_W-1:0]);
      adv_row      = 1'b0;

      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
      if (csr_valid) begin
         attr_in = csr_wdata;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (q_valid) begin
               q_pop    = 1'b1;
               cmd_in   = q_cmd;
               value_in = '0;
               state_in = ST_DONE;
               unique case (q_cmd.op)
                  tcw_pkg::OP_PRINT: begin
                     prow_in  = cur_prow;
                     fill_in  = '0;
                     state_in = row_valid_ff[cur_prow] ? ST_WRITE : ST_FILL;
                  end
                  tcw_pkg::OP_BS: begin
                     if (col_ff != '0) begin
                        col_in   = col_ff - 1'b1;
                        phase_in = (phase_ff == '0) ? PHASE_W'(tcw_pkg::TAB_WIDTH - 1)
                                                    : phase_ff - 1'b1;
                     end
                  end
                  tcw_pkg::OP_TAB: begin
                     phase_in = '0;
                     if (tab_col >= TABSUM_W'(tcw_pkg::COLUMNS)) begin
                        col_in  = '0;
                        adv_row = 1'b1;
                     end else begin
                        col_in = tab_col[COL_W-1:0];
                     end
                  end
                  tcw_pkg::OP_CR: begin
                     col_in   = '0;
                     phase_in = '0;
                  end
                  tcw_pkg::OP_LF: begin
                     col_in   = '0;
                     phase_in = '0;
                     adv_row  = 1'b1;
                  end
                  tcw_pkg::OP_CLEAR: begin
                     col_in       = '0;
                     phase_in     = '0;
                     row_in       = '0;
                     top_in       = '0;
                     row_valid_in = '0;
                     for (int i = 0; i < ROWS; i++) begin
                        row_attr_in[i] = attr_ff;
                     end
                  end
                  tcw_pkg::OP_READ: begin
                     rem_in   = q_cmd.cell_index;
                     quo_in   = '0;
                     state_in = ST_DIV;
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_FILL: begin
            // first write to a blanked row: paint the whole row with its blank
            mem_we    = 1'b1;
            mem_waddr = cell_addr(prow_ff, fill_ff);
            mem_wdata = {row_attr_ff[prow_ff], tcw_pkg::CH_SPACE};
            if (fill_ff == COL_W'(tcw_pkg::COLUMNS - 1)) begin
               row_valid_in[prow_ff] = 1'b1;
               state_in              = ST_WRITE;
            end else begin
               fill_in = fill_ff + 1'b1;
            end
         end
         ST_WRITE: begin
            mem_we   = 1'b1;
            state_in = ST_DONE;
            if (col_ff == COL_W'(tcw_pkg::COLUMNS - 1)) begin
               col_in   = '0;
               phase_in = '0;
               adv_row  = 1'b1;
            end else begin
               col_in   = col_ff + 1'b1;
               phase_in = (phase_ff == PHASE_W'(tcw_pkg::TAB_WIDTH - 1)) ? '0
                                                                         : phase_ff + 1'b1;
            end
         end
         ST_DIV: begin
            // row of the index: reciprocal multiply by 1/COLUMNS
            quo_in   = ROW_W'(quo_prod >> tcw_pkg::RECIP_SHIFT);
            state_in = ST_REM;
         end
         ST_REM: begin
            // column of the index
            rem_in   = rem_ff - IDX_W'(quo_ff) * IDX_W'(tcw_pkg::COLUMNS);
            state_in = ST_LOOK;
         end
         ST_LOOK: begin
            if (row_valid_ff[look_prow]) begin
               state_in = ST_RDATA;
            end else begin
               value_in = {row_attr_ff[look_prow], tcw_pkg::CH_SPACE};
               state_in = ST_DONE;
            end
         end
         ST_RDATA: begin
            value_in = rd_data_ff;
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in           = 1'b1;
               rsp_data_in.cursor_pos = POS_W'(cur_lin);
               rsp_data_in.cell_value = value_ff;
               state_in               = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase

      // newline: next row, or scroll by retiring the top physical row
      if (adv_row) begin
         if (row_ff == ROW_W'(ROWS - 1)) begin
            top_in              = (top_ff == ROW_W'(ROWS - 1)) ? '0 : top_ff + 1'b1;
            row_valid_in[top_ff] = 1'b0;
            row_attr_in[top_ff]  = attr_ff;
         end else begin
            row_in = row_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         attr_ff      <= tcw_pkg::ATTR_RESET;
         col_ff       <= '0;
         phase_ff     <= '0;
         row_ff       <= '0;
         top_ff       <= '0;
         row_valid_ff <= '0;
         for (int i = 0; i < ROWS; i++) begin
            row_attr_ff[i] <= tcw_pkg::ATTR_RESET;
         end
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         attr_ff      <= attr_in;
         col_ff       <= col_in;
         phase_ff     <= phase_in;
         row_ff       <= row_in;
         top_ff       <= top_in;
         row_valid_ff <= row_valid_in;
         row_attr_ff  <= row_attr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff      <= cmd_in;
      fill_ff     <= fill_in;
      rem_ff      <= rem_in;
      quo_ff      <= quo_in;
      prow_ff     <= prow_in;
      value_ff    <= value_in;
      rsp_data_ff <= rsp_data_in;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         cells[mem_waddr] <= mem_wdata;
      end
      rd_data_ff <= cells[mem_raddr];
   end

endmodule

// ===== rtl/core/tcw_checker.sv =====
`timescale 1ns / 1ps
// tcw_checker: port-level assertions for text_console_writer, bound to the top.
// Depends on tcw_pkg.
module tcw_checker (
   input logic                       clock,
   input logic                       reset,
   input logic                       rsp_valid,
   input logic                       rsp_stall,
   input tcw_pkg::rsp_type           rsp_data,
   input logic                       csr_ready
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("response dropped while stalled");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> $stable(rsp_data))
      else $error("stalled response changed");

   a_cursor_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> 32'(rsp_data.cursor_pos) < tcw_pkg::CELL_COUNT)
      else $error("cursor position off screen");

   a_reset_quiet: assert property (@(posedge clock) disable iff (reset)
      $past(reset) |-> !rsp_valid)
      else $error("response right after reset");

   a_csr_ready: assert property (@(posedge clock) disable iff (reset)
      csr_ready)
      else $error("attribute write refused");

endmodule

bind text_console_writer tcw_checker u_tcw_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data),
   .csr_ready (csr_ready)
);
